// File: sv/assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define VDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset too.
`define VDU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/vdu_pkg.sv
`default_nettype none
package vdu_pkg;

    localparam int COMP_W  = 16;
    localparam int MAG_W   = COMP_W + 1;
    localparam int TERM_W  = 2 * MAG_W;
    localparam int SUM_W   = 44;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int STEP_W  = $clog2(ROOT_W);
    localparam int MODE_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROOT      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARED   = 2'd2;

    localparam logic REG_MODE_IDX = 1'b0;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_value;
        logic signed [COMP_W-1:0] b_value;
        logic                     last_pair;
    } t_in_req;

    typedef struct packed {
        logic [SUM_W-1:0] distance;
        logic             saturated;
    } t_out_req;

    // One finished vector handed from the accumulator to the result side.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             clip;
        logic             root;
    } t_job;

endpackage
`default_nettype wire

// File: sv/vector_distance_unit.sv
// The square-root mode uses a 22-step digit-by-digit root unit.
// Throughput: one component pair per cycle, except while the last pair of a
// vector waits on a full queue; the root unit finishes one vector before
// it takes the next, and a two-entry queue holds finished sums ahead of it.
// Reset: synchronous, active low; clears sums, queue, root unit and mode.
`default_nettype none
module vector_distance_unit import vdu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_req           i_in_req,
    input  wire logic              pop,
    output logic                   empty,
    output t_out_req               o_out_req,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [MODE_W-1:0] r_mode;
    t_job              fq_job;
    logic              fq_push;
    logic              q_full;
    t_job              qb_job;
    logic              q_empty;
    logic              q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE_IDX) ? DATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MANHATTAN;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE_IDX) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    vdu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_push     (push),
        .o_full     (full),
        .i_req      (i_in_req),
        .o_job      (fq_job),
        .o_job_push (fq_push),
        .i_q_full   (q_full)
    );

    vdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_job   (fq_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (qb_job),
        .o_empty (q_empty)
    );

    vdu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (qb_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_req     (o_out_req),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule
`default_nettype wire

// File: sv/vdu_front.sv
`default_nettype none
module vdu_front import vdu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire t_in_req           i_req,
    output t_job                   o_job,
    output logic                   o_job_push,
    input  wire logic              i_q_full
);

    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic [MODE_W-1:0]       r_s1_mode;
    logic [MAG_W-1:0]        r_s1_mag;
    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic                    r_s2_root;
    logic [TERM_W-1:0]       r_s2_term;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_clip;

    logic                    en;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [TERM_W-1:0]       term;
    logic [SUM_W:0]          sum_ext;
    logic [SUM_W-1:0]        n_sum;
    logic                    n_clip;

    assign en     = !(r_s2_valid && r_s2_last && i_q_full);
    assign o_full = !en;

    assign diff = $signed({i_req.a_value[COMP_W-1], i_req.a_value})
                - $signed({i_req.b_value[COMP_W-1], i_req.b_value});
    assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    assign term = (r_s1_mode == MODE_MANHATTAN) ? TERM_W'(r_s1_mag)
                                                : r_s1_mag * r_s1_mag;

    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_s2_term);
    assign n_sum   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign n_clip  = r_clip | sum_ext[SUM_W];

    assign o_job_push = en && r_s2_valid && r_s2_last;
    assign o_job.sum  = n_sum;
    assign o_job.clip = n_clip;
    assign o_job.root = r_s2_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_sum      <= '0;
            r_clip     <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_push;
            r_s1_last  <= i_req.last_pair;
            r_s1_mode  <= i_mode;
            r_s1_mag   <= mag;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_s2_root  <= (r_s1_mode == MODE_ROOT);
            r_s2_term  <= term;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_sum  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_sum  <= n_sum;
                    r_clip <= n_clip;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/vdu_queue.sv
`default_nettype none
module vdu_queue import vdu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

// File: sv/vdu_back.sv
`default_nettype none
module vdu_back import vdu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_q_empty,
    output logic      o_q_pop,
    output t_out_req  o_req,
    output logic      o_empty,
    input  wire logic i_pop
);

    typedef enum logic {ST_IDLE, ST_ROOT} t_state;

    t_state            r_state;
    logic              r_out_valid;
    t_out_req          r_out;
    logic [SUM_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_clip;

    logic              start;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [ROOT_W-1:0] n_root;
    logic [REM_W+1:0]  rem_diff;

    assign start   = (r_state == ST_IDLE) && !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = start;
    assign o_empty = !r_out_valid;
    assign o_req   = r_out;

    assign rem_sh   = {r_rem, r_rad[SUM_W-1 -: 2]};
    assign trial    = (REM_W + 2)'({r_root, 2'b01});
    assign take     = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;
    assign n_root   = {r_root[ROOT_W-2:0], take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (i_job.root) begin
                            r_state <= ST_ROOT;
                            r_rad   <= i_job.sum;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_step  <= '0;
                            r_clip  <= i_job.clip;
                        end else begin
                            r_out_valid     <= 1'b1;
                            r_out.distance  <= i_job.sum;
                            r_out.saturated <= i_job.clip;
                        end
                    end
                end
                ST_ROOT: begin
                    r_rad  <= {r_rad[SUM_W-3:0], 2'b00};
                    r_rem  <= take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                    r_root <= n_root;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(ROOT_W - 1)) begin
                        r_state         <= ST_IDLE;
                        r_out_valid     <= 1'b1;
                        r_out.distance  <= SUM_W'(n_root);
                        r_out.saturated <= r_clip;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/vdu_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vdu_checker import vdu_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              pop,
    input wire logic              empty,
    input wire t_out_req          o_out_req,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pready
);

    `VDU_ASSERT_RST(a_empty_after_reset, !i_rst_n |=> empty, "result after reset")
    `VDU_ASSERT_RST(a_ready_after_reset, !i_rst_n |=> !full, "full after reset")
    `VDU_ASSERT_RST(a_pready_high, pready, "pready low")
    `VDU_ASSERT(a_mode_readback, (psel && penable && pwrite && paddr == '0) |=> (paddr != '0 || prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0])), "mode readback mismatch")
    `VDU_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(o_out_req)), "waiting result changed")

endmodule

bind vector_distance_unit vdu_checker u_vdu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .o_out_req (o_out_req),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
`default_nettype wire
